[rtl/core/lrcf_pkg.sv]
// lrcf_pkg: shared types, constants and helpers for the led ring clock face core
// no dependencies; imported by every module under rtl/core

package lrcf_pkg;

  // ring geometry
  localparam int unsigned RingSize  = 60;
  localparam logic [5:0]  LastPixel = 6'd59;

  // colour register reset values
  localparam logic [23:0] HourHandReset   = 24'hF000F0;
  localparam logic [23:0] HourSideReset   = 24'h200020;
  localparam logic [23:0] HourMarkReset   = 24'h202020;
  localparam logic [23:0] MinuteHandReset = 24'h00FF00;
  localparam logic [23:0] SecondHandReset = 24'hFF0000;

  // input op codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_HOUR_HAND   = 3'd0,
    REG_HOUR_SIDE   = 3'd1,
    REG_HOUR_MARK   = 3'd2,
    REG_MINUTE_HAND = 3'd3,
    REG_SECOND_HAND = 3'd4
  } reg_idx_t;

  // colour set handed from the register file to the pixel stage
  typedef struct packed {
    logic [23:0] hour_hand;
    logic [23:0] hour_side;
    logic [23:0] hour_mark;
    logic [23:0] minute_hand;
    logic [23:0] second_hand;
  } colors_t;

  // pixel positions of one frame, all already mirrored onto the ring
  typedef struct packed {
    logic [5:0] centre;
    logic [5:0] left;
    logic [5:0] right;
    logic [5:0] minute_px;
    logic [5:0] second_px;
  } frame_t;

  // hour marks sit at time positions 0, 5, ..., 55, so at pixels 4, 9, ..., 59
  function automatic logic is_mark(input logic [5:0] k);
    logic hit;
    case (k) inside
      6'd4, 6'd9, 6'd14, 6'd19, 6'd24, 6'd29,
      6'd34, 6'd39, 6'd44, 6'd49, 6'd54, 6'd59: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // minute or second value folded onto the ring (60..63 drawn as 0..3)
  function automatic logic [5:0] draw_value(input logic [5:0] v);
    return (v >= 6'd60) ? (v - 6'd60) : v;
  endfunction

endpackage

[rtl/core/lrcf_regs.sv]
// lrcf_regs: apb-style colour register file
// depends on lrcf_pkg for register indexes, reset colours and colors_t

module lrcf_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output lrcf_pkg::colors_t colors
);
  import lrcf_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      colors.hour_hand   <= HourHandReset;
      colors.hour_side   <= HourSideReset;
      colors.hour_mark   <= HourMarkReset;
      colors.minute_hand <= MinuteHandReset;
      colors.second_hand <= SecondHandReset;
    end else if (wr_en) begin
      case (idx)
        REG_HOUR_HAND:   colors.hour_hand   <= pwdata[23:0];
        REG_HOUR_SIDE:   colors.hour_side   <= pwdata[23:0];
        REG_HOUR_MARK:   colors.hour_mark   <= pwdata[23:0];
        REG_MINUTE_HAND: colors.minute_hand <= pwdata[23:0];
        REG_SECOND_HAND: colors.second_hand <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_HOUR_HAND:   prdata = {8'd0, colors.hour_hand};
      REG_HOUR_SIDE:   prdata = {8'd0, colors.hour_side};
      REG_HOUR_MARK:   prdata = {8'd0, colors.hour_mark};
      REG_MINUTE_HAND: prdata = {8'd0, colors.minute_hand};
      REG_SECOND_HAND: prdata = {8'd0, colors.second_hand};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

[rtl/core/lrcf_time.sv]
// lrcf_time: time-of-day registers and per-frame hand positions
// depends on lrcf_pkg for frame_t, op codes and draw helpers

module lrcf_time (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             op,
  input  logic [4:0]       load_hour,
  input  logic [5:0]       load_minute,
  input  logic [5:0]       load_second,
  output lrcf_pkg::frame_t frame
);
  import lrcf_pkg::*;

  logic [3:0]  hours_now, hours_next;
  logic [5:0]  minutes_now, minutes_next;
  logic [5:0]  seconds_now, seconds_next;
  logic [3:0]  load_h12;
  logic [3:0]  h12;
  logic [5:0]  m_draw, s_draw;
  logic [11:0] m_prod;
  logic [2:0]  m_div12;
  logic [5:0]  hour_pos;
  logic [5:0]  centre;
  frame_t      frame_next;

  // load hour modulo 12 by two compare-subtracts
  always_comb begin
    if (load_hour >= 5'd24)      load_h12 = 4'(load_hour - 5'd24);
    else if (load_hour >= 5'd12) load_h12 = 4'(load_hour - 5'd12);
    else                         load_h12 = load_hour[3:0];
  end

  // load or advance one second with carries
  always_comb begin
    hours_next   = hours_now;
    minutes_next = minutes_now;
    seconds_next = seconds_now;
    if (op == OP_LOAD) begin
      hours_next   = load_h12;
      minutes_next = load_minute;
      seconds_next = load_second;
    end else if (seconds_now >= 6'd59) begin
      seconds_next = 6'd0;
      if (minutes_now >= 6'd59) begin
        minutes_next = 6'd0;
        hours_next   = (hours_now >= 4'd11) ? 4'd0 : hours_now + 4'd1;
      end else begin
        minutes_next = minutes_now + 6'd1;
      end
    end else begin
      seconds_next = seconds_now + 6'd1;
    end
  end

  // hand positions of the updated time, mirrored onto the reversed ring
  always_comb begin
    m_draw   = draw_value(minutes_next);
    s_draw   = draw_value(seconds_next);
    h12      = (hours_next >= 4'd12) ? hours_next - 4'd12 : hours_next;
    // minute / 12 for 0..59 as (m * 43) >> 9
    m_prod   = {6'd0, m_draw} * 12'd43;
    m_div12  = m_prod[11:9];
    hour_pos = {h12, 2'b00} + {2'b00, h12} + {3'd0, m_div12};
    centre   = LastPixel - hour_pos;
    frame_next.centre    = centre;
    frame_next.left      = (centre == 6'd0) ? LastPixel : centre - 6'd1;
    frame_next.right     = (centre == LastPixel) ? 6'd0 : centre + 6'd1;
    frame_next.minute_px = LastPixel - m_draw;
    frame_next.second_px = LastPixel - s_draw;
  end

  // time state
  always_ff @(posedge clk) begin
    if (rst) begin
      hours_now   <= 4'd0;
      minutes_now <= 6'd0;
      seconds_now <= 6'd0;
    end else if (accept) begin
      hours_now   <= hours_next;
      minutes_now <= minutes_next;
      seconds_now <= seconds_next;
    end
  end

  // frame descriptor, held for the whole frame
  always_ff @(posedge clk) begin
    if (accept) begin
      frame <= frame_next;
    end
  end

  a_hours_range: assert property (@(posedge clk) disable iff (rst)
    hours_now < 4'd12)
    else $error("hour state left 0..11");

endmodule

[rtl/core/lrcf_pixel.sv]
// lrcf_pixel: frame sequencer, per-pixel colour select and output register
// depends on lrcf_pkg for frame_t, colors_t and is_mark

module lrcf_pixel (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              accept,
  input  lrcf_pkg::frame_t  frame,
  input  lrcf_pkg::colors_t colors,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        pixel_index,
  output logic [23:0]       pixel_color,
  output logic              frame_last
);
  import lrcf_pkg::*;

  logic        busy;
  logic [5:0]  count;
  logic        advance;
  logic        last_px;
  logic [23:0] color_next;

  // handshake: a new item enters as the last pixel moves to the output
  assign advance  = busy && (!out_valid || !out_stall);
  assign last_px  = (count == LastPixel);
  assign in_stall = busy && !(advance && last_px);
  assign accept   = in_valid && !in_stall;

  // layered colour for the current pixel, top layer first
  always_comb begin
    if (count == frame.second_px)                        color_next = colors.second_hand;
    else if (count == frame.minute_px)                   color_next = colors.minute_hand;
    else if (is_mark(count))                             color_next = colors.hour_mark;
    else if (count == frame.left || count == frame.right) color_next = colors.hour_side;
    else if (count == frame.centre)                      color_next = colors.hour_hand;
    else                                                 color_next = 24'd0;
  end

  // frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= 6'd0;
    end else if (accept) begin
      busy  <= 1'b1;
      count <= 6'd0;
    end else if (advance) begin
      if (last_px) begin
        busy <= 1'b0;
      end else begin
        count <= count + 6'd1;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_index <= count;
      pixel_color <= color_next;
      frame_last  <= last_px;
    end
  end

  a_last_on_59: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> pixel_index == LastPixel)
    else $error("frame end flagged off the last pixel");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && count == 6'd0)
    else $error("accepted item did not start a frame");

  a_idle_open: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !in_stall)
    else $error("input stalled while no frame is in progress");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> count <= LastPixel)
    else $error("pixel counter beyond the ring");

endmodule

[rtl/core/led_ring_clock_face_core.sv]
// led_ring_clock_face_core: top level of the led ring clock face
// depends on lrcf_pkg, lrcf_regs, lrcf_time and lrcf_pixel

// Each input transfer loads the time (op 0) or advances it one second (op 1)
// and then yields one 60-pixel frame, pixels 0 to 59 in order, one pixel
// transfer per cycle while the output does not stall. The next input
// transfer is taken in the same cycle the last pixel of the current frame
// enters the output register, so with no stall on the output, frames
// stream back to back. A stall on the output holds the current pixel in the
// output register and, while the last pixel of a frame is waiting, stalls
// the input in the same cycle. Colour registers sit at byte addresses 0, 4,
// 8, 12 and 16 and should be written only while idle.

module led_ring_clock_face_core (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [4:0]  load_hour,
  input  logic [5:0]  load_minute,
  input  logic [5:0]  load_second,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  pixel_index,
  output logic [23:0] pixel_color,
  output logic        frame_last
);
  import lrcf_pkg::*;

  colors_t colors;
  frame_t  frame;
  logic    accept;

  lrcf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .colors  (colors)
  );

  lrcf_time u_time (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .op          (op),
    .load_hour   (load_hour),
    .load_minute (load_minute),
    .load_second (load_second),
    .frame       (frame)
  );

  lrcf_pixel u_pixel (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .accept      (accept),
    .frame       (frame),
    .colors      (colors),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_index (pixel_index),
    .pixel_color (pixel_color),
    .frame_last  (frame_last)
  );

endmodule

[tb/sv/led_ring_clock_face_core_test.sv]
// led_ring_clock_face_core_test: self-checking bench for the led ring clock face core
// predicts every 60-pixel frame from the time updates and colour writes
// depends on lrcf_pkg and led_ring_clock_face_core
`timescale 1ns / 1ps

import lrcf_pkg::*;

// tracks the clock time and colours, and holds the pixels still to come
class clock_face_tracker;
  typedef struct {
    logic [5:0]  num;
    logic [23:0] color;
    logic        last;
  } pixel_t;

  logic [23:0] hand_color;
  logic [23:0] side_color;
  logic [23:0] mark_color;
  logic [23:0] minute_color;
  logic [23:0] second_color;
  logic [3:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  pixel_t      pixels_due[$];
  int unsigned faults;

  function new();
    hand_color   = HourHandReset;
    side_color   = HourSideReset;
    mark_color   = HourMarkReset;
    minute_color = MinuteHandReset;
    second_color = SecondHandReset;
    hours        = '0;
    minutes      = '0;
    seconds      = '0;
    faults       = 0;
  endfunction

  function void set_color(reg_idx_t idx, logic [23:0] value);
    case (idx)
      REG_HOUR_HAND:   hand_color = value;
      REG_HOUR_SIDE:   side_color = value;
      REG_HOUR_MARK:   mark_color = value;
      REG_MINUTE_HAND: minute_color = value;
      REG_SECOND_HAND: second_color = value;
      default: ;
    endcase
  endfunction

  // update the time from one input transfer and queue the frame it draws
  function void take_time(logic op_bit, logic [4:0] lh, logic [5:0] lm, logic [5:0] ls);
    logic [23:0] ring [60];
    int          m;
    int          s;
    int          centre;
    int          k;
    pixel_t      px;
    if (op_bit == OP_LOAD) begin
      hours   = 4'(lh % 12);
      minutes = lm;
      seconds = ls;
    end else if (seconds >= 59) begin
      // out-of-range seconds and minutes also wrap with a carry
      seconds = '0;
      if (minutes >= 59) begin
        minutes = '0;
        hours   = (hours >= 11) ? 4'd0 : hours + 4'd1;
      end else begin
        minutes = minutes + 6'd1;
      end
    end else begin
      seconds = seconds + 6'd1;
    end

    // 60..63 fold back onto the start of the ring
    m = (minutes >= 60) ? minutes - 60 : minutes;
    s = (seconds >= 60) ? seconds - 60 : seconds;
    centre = 59 - ((hours % 12) * 5 + m / 12);

    // layers, later ones win
    for (k = 0; k < 60; k++) ring[k] = '0;
    ring[centre] = hand_color;
    ring[(centre + 59) % 60] = side_color;
    ring[(centre + 1) % 60] = side_color;
    for (k = 0; k < 12; k++) ring[59 - 5 * k] = mark_color;
    ring[59 - m] = minute_color;
    ring[59 - s] = second_color;

    for (k = 0; k < 60; k++) begin
      px.num   = 6'(k);
      px.color = ring[k];
      px.last  = (k == 59);
      pixels_due.push_back(px);
    end
  endfunction

  function void report(string what, logic [31:0] want_v, logic [31:0] got_v);
    faults++;
    if (faults <= 10)
      $display("mismatch in %s: expected %0h, actual %0h", what, want_v, got_v);
  endfunction

  // compare one output transfer with the oldest pending pixel
  function void check_pixel(logic [5:0] num, logic [23:0] color, logic last);
    pixel_t want;
    if (pixels_due.size() == 0) begin
      faults++;
      if (faults <= 10)
        $display("pixel %0d color %0h arrived with no frame pending", num, color);
      return;
    end
    want = pixels_due.pop_front();
    if (num !== want.num) report("pixel_index", want.num, num);
    if (color !== want.color) report($sformatf("pixel_color of pixel %0d", want.num),
                                     want.color, color);
    if (last !== want.last) report($sformatf("frame_last of pixel %0d", want.num),
                                   want.last, last);
  endfunction
endclass

module led_ring_clock_face_core_test;
  localparam int QuietLimit = 2000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [4:0]  load_hour;
  logic [5:0]  load_minute;
  logic [5:0]  load_second;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  pixel_index;
  logic [23:0] pixel_color;
  logic        frame_last;

  bit          in_idle_on;
  bit          out_idle_on;
  int          quiet;

  clock_face_tracker tracker = new();

  led_ring_clock_face_core dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .op, .load_hour, .load_minute, .load_second,
    .out_valid, .out_stall, .pixel_index, .pixel_color, .frame_last
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // input transfers update the predicted time
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      tracker.take_time(op, load_hour, load_minute, load_second);
  end

  // output transfers are checked against the predicted frame
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      tracker.check_pixel(pixel_index, pixel_color, frame_last);
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pwrite && pready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("led_ring_clock_face_core_test: done, errors");
        $finish;
      end
    end
  end

  // random stall bursts on the output side
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // one register write: setup, access, then psel low again
  task automatic write_color(reg_idx_t idx, logic [23:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {8'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_color(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_palette(logic [23:0] hand, logic [23:0] side, logic [23:0] mark,
                               logic [23:0] minute, logic [23:0] second);
    write_color(REG_HOUR_HAND, hand);
    write_color(REG_HOUR_SIDE, side);
    write_color(REG_HOUR_MARK, mark);
    write_color(REG_MINUTE_HAND, minute);
    write_color(REG_SECOND_HAND, second);
  endtask

  // present one time update and hold it until the transfer
  task automatic send_time(logic o, logic [4:0] h, logic [5:0] m, logic [5:0] s);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    load_hour   <= h;
    load_minute <= m;
    load_second <= s;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // mostly advances, with loads that often land just before a carry
  task automatic send_random_time();
    int          pick;
    logic [4:0]  h;
    logic [5:0]  m;
    logic [5:0]  s;
    pick = $urandom_range(0, 9);
    h = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 23));
    if (pick < 3) begin
      m = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
      s = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 60));
      send_time(OP_LOAD, h, m, s);
    end else if (pick == 3) begin
      m = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(60, 63)) : 6'($urandom_range(57, 59));
      s = 6'($urandom_range(57, 63));
      send_time(OP_LOAD, h, m, s);
    end else begin
      send_time(OP_ADVANCE, 5'($urandom), 6'($urandom), 6'($urandom));
    end
  endtask

  // drop valid and wait for every pending pixel to drain
  task automatic drain(int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pixels_due.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  initial begin
    rst         <= 1'b1;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid    <= 1'b0;
    op          <= OP_LOAD;
    load_hour   <= '0;
    load_minute <= '0;
    load_second <= '0;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed frames with the reset colours
    send_time(OP_LOAD, 5'd0, 6'd0, 6'd0);        // hour hand on mark 12, side wraps to pixel 0
    send_time(OP_ADVANCE, 5'd31, 6'd63, 6'd63);  // load fields ignored
    send_time(OP_LOAD, 5'd23, 6'd59, 6'd59);
    send_time(OP_ADVANCE, 5'd0, 6'd0, 6'd0);     // 11:59:59 wraps to 0:00:00
    send_time(OP_LOAD, 5'd11, 6'd59, 6'd58);
    send_time(OP_ADVANCE, 5'd0, 6'd0, 6'd0);
    send_time(OP_ADVANCE, 5'd0, 6'd0, 6'd0);
    send_time(OP_LOAD, 5'd12, 6'd30, 6'd60);     // leap second drawn at 0
    send_time(OP_ADVANCE, 5'd0, 6'd0, 6'd0);     // leap second carries
    send_time(OP_LOAD, 5'd31, 6'd63, 6'd63);     // all ones, folded values
    send_time(OP_ADVANCE, 5'd0, 6'd0, 6'd0);     // out-of-range carry through hours
    send_time(OP_LOAD, 5'd5, 6'd60, 6'd61);
    send_time(OP_ADVANCE, 5'd0, 6'd0, 6'd0);
    send_time(OP_LOAD, 5'd16, 6'd48, 6'd7);
    send_time(OP_LOAD, 5'd11, 6'd48, 6'd30);     // hour hand at last position, side wraps
    send_time(OP_LOAD, 5'd6, 6'd12, 6'd12);      // second over minute
    send_time(OP_LOAD, 5'd3, 6'd15, 6'd15);      // minute and second on a mark
    send_time(OP_LOAD, 5'd10, 6'd0, 6'd0);
    send_time(OP_LOAD, 5'd0, 6'd59, 6'd60);
    send_time(OP_ADVANCE, 5'd0, 6'd0, 6'd0);     // minute 59 carries into hour
    send_time(OP_LOAD, 5'd22, 6'd62, 6'd59);
    send_time(OP_ADVANCE, 5'd0, 6'd0, 6'd0);
    send_time(OP_LOAD, 5'd1, 6'd2, 6'd3);
    drain(4);

    // all colours at full scale
    write_palette(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    repeat (10) send_random_time();
    drain(4);

    // all colours dark
    write_palette(24'h0, 24'h0, 24'h0, 24'h0, 24'h0);
    repeat (10) send_random_time();
    drain(4);

    // random colours
    write_palette(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
    repeat (40) send_random_time();
    drain(4);

    // mixed extremes, last stretch with no idling on either side
    write_palette(24'h0, 24'hFFFFFF, 24'($urandom), 24'hFFFFFF, 24'($urandom));
    repeat (20) send_random_time();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    repeat (20) send_random_time();
    drain(20);

    if (tracker.pixels_due.size() != 0) begin
      tracker.faults++;
      $display("%0d pixels never arrived", tracker.pixels_due.size());
    end
    if (tracker.faults == 0)
      $display("led_ring_clock_face_core_test: done, clean");
    else
      $display("led_ring_clock_face_core_test: done, errors");
    $finish;
  end
endmodule
